// File: rtl/esgd_pkg.sv
// Package for the edge swipe gesture detector.
// Holds register codes, reset values, gesture codes and the configuration struct.
// No dependencies.
`default_nettype none
package esgd_pkg;

	localparam int MAX_FINGERS_DEF = 10;
	localparam int COORD_BITS_DEF  = 12;
	localparam int QUEUE_DEPTH     = 4;
	localparam int REG_BITS        = 12;
	localparam int WIN_BITS        = 16;
	localparam int TIME_BITS       = 32;
	localparam int FINGER_BITS     = 4;
	localparam int DRAG_MIN_TRAVEL = 100;

	localparam logic [2:0] REG_SLIDE_X_START    = 3'd0;
	localparam logic [2:0] REG_SLIDE_X_END      = 3'd1;
	localparam logic [2:0] REG_SLIDE_MIN_TRAVEL = 3'd2;
	localparam logic [2:0] REG_EDGE_Y_LIMIT     = 3'd3;
	localparam logic [2:0] REG_EDGE_AT_HIGH_Y   = 3'd4;
	localparam logic [2:0] REG_SWIPE_WINDOW_MS  = 3'd5;
	localparam logic [2:0] REG_DRAG_START_LIMIT = 3'd6;
	localparam logic [2:0] REG_DRAG_Y_TOLERANCE = 3'd7;

	localparam logic [1:0] GEST_NONE       = 2'd0;
	localparam logic [1:0] GEST_SWIPE_UP   = 2'd1;
	localparam logic [1:0] GEST_SWIPE_DOWN = 2'd2;
	localparam logic [1:0] GEST_DRAG       = 2'd3;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	typedef struct packed {
		logic [REG_BITS-1:0] x_start;
		logic [REG_BITS-1:0] x_end;
		logic [REG_BITS-1:0] min_travel;
		logic [REG_BITS-1:0] y_limit;
		logic                at_high_y;
		logic [WIN_BITS-1:0] window_ms;
		logic [REG_BITS-1:0] drag_limit;
		logic [REG_BITS-1:0] y_tol;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		x_start:    12'd528,
		x_end:      12'd1340,
		min_travel: 12'd325,
		y_limit:    12'd3,
		at_high_y:  1'b0,
		window_ms:  16'd1999,
		drag_limit: 12'd50,
		y_tol:      12'd100
	};

endpackage
`default_nettype wire

// File: rtl/edge_swipe_gesture_detector.sv
// Top level of the edge swipe gesture detector: register port, front, queue and back.
// Depends on esgd_pkg, esgd_front, esgd_queue and esgd_back.
//
//  port group   direction  handshake                        payload
//  touch in     in         in_valid / in_stall              finger pos_x pos_y touching now_ms
//  gesture out  out        out_valid / out_stall            gesture status
//  registers    in         psel penable pwrite pready       paddr pwdata prdata
//
//  One transaction per cycle unless stalled; path is input register, queue, output register.
//  The per-finger stroke table read-modify-write in the back part sets the rate.
//  Reset clears every stroke's valid and done flags, loads register defaults; no clearing pass.
//  The queue lets the front keep taking input while the output is stalled.
`default_nettype none
module edge_swipe_gesture_detector #(
	parameter int MAX_FINGERS = esgd_pkg::MAX_FINGERS_DEF,
	parameter int COORD_BITS  = esgd_pkg::COORD_BITS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             psel,
	input  wire                             penable,
	input  wire                             pwrite,
	input  wire [4:0]                       paddr,
	input  wire [31:0]                      pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire [esgd_pkg::FINGER_BITS-1:0] finger,
	input  wire [COORD_BITS-1:0]            pos_x,
	input  wire [COORD_BITS-1:0]            pos_y,
	input  wire                             touching,
	input  wire [esgd_pkg::TIME_BITS-1:0]   now_ms,
	output logic                            out_valid,
	input  wire                             out_stall,
	output logic [1:0]                      gesture,
	output logic                            status
);
	import esgd_pkg::*;

	localparam int ENTRY_W = 3 + FINGER_BITS + 2 * COORD_BITS + TIME_BITS;

	cfg_t               cfg_q;
	logic               wr_en;
	logic [2:0]         reg_idx;
	logic               push;
	logic               pop;
	logic               full;
	logic               empty;
	logic [ENTRY_W-1:0] push_data;
	logic [ENTRY_W-1:0] head;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SLIDE_X_START:    cfg_q.x_start    <= pwdata[REG_BITS-1:0];
				REG_SLIDE_X_END:      cfg_q.x_end      <= pwdata[REG_BITS-1:0];
				REG_SLIDE_MIN_TRAVEL: cfg_q.min_travel <= pwdata[REG_BITS-1:0];
				REG_EDGE_Y_LIMIT:     cfg_q.y_limit    <= pwdata[REG_BITS-1:0];
				REG_EDGE_AT_HIGH_Y:   cfg_q.at_high_y  <= pwdata[0];
				REG_SWIPE_WINDOW_MS:  cfg_q.window_ms  <= pwdata[WIN_BITS-1:0];
				REG_DRAG_START_LIMIT: cfg_q.drag_limit <= pwdata[REG_BITS-1:0];
				REG_DRAG_Y_TOLERANCE: cfg_q.y_tol      <= pwdata[REG_BITS-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SLIDE_X_START:    prdata = 32'(cfg_q.x_start);
			REG_SLIDE_X_END:      prdata = 32'(cfg_q.x_end);
			REG_SLIDE_MIN_TRAVEL: prdata = 32'(cfg_q.min_travel);
			REG_EDGE_Y_LIMIT:     prdata = 32'(cfg_q.y_limit);
			REG_EDGE_AT_HIGH_Y:   prdata = 32'(cfg_q.at_high_y);
			REG_SWIPE_WINDOW_MS:  prdata = 32'(cfg_q.window_ms);
			REG_DRAG_START_LIMIT: prdata = 32'(cfg_q.drag_limit);
			REG_DRAG_Y_TOLERANCE: prdata = 32'(cfg_q.y_tol);
		endcase
	end

	esgd_front #(
		.MAX_FINGERS (MAX_FINGERS),
		.COORD_BITS  (COORD_BITS),
		.ENTRY_W     (ENTRY_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.finger    (finger),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.touching  (touching),
		.now_ms    (now_ms),
		.push      (push),
		.full      (full),
		.push_data (push_data)
	);

	esgd_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.head      (head)
	);

	esgd_back #(
		.MAX_FINGERS (MAX_FINGERS),
		.COORD_BITS  (COORD_BITS),
		.ENTRY_W     (ENTRY_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.gesture   (gesture),
		.status    (status)
	);

endmodule
`default_nettype wire

// File: rtl/esgd_front.sv
// Front part of the edge swipe gesture detector: input register and classification.
// Flags out-of-range fingers and edge-strip membership, then pushes into the queue.
// Depends on esgd_pkg.
`default_nettype none
module esgd_front #(
	parameter int MAX_FINGERS = esgd_pkg::MAX_FINGERS_DEF,
	parameter int COORD_BITS  = esgd_pkg::COORD_BITS_DEF,
	parameter int ENTRY_W     = 3 + esgd_pkg::FINGER_BITS + 2 * COORD_BITS
		+ esgd_pkg::TIME_BITS
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire esgd_pkg::cfg_t                cfg,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire [esgd_pkg::FINGER_BITS-1:0]    finger,
	input  wire [COORD_BITS-1:0]               pos_x,
	input  wire [COORD_BITS-1:0]               pos_y,
	input  wire                                touching,
	input  wire [esgd_pkg::TIME_BITS-1:0]      now_ms,
	output logic                               push,
	input  wire                                full,
	output logic [ENTRY_W-1:0]                 push_data
);
	import esgd_pkg::*;

	localparam int CW = (COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS;
	typedef logic [CW-1:0] cw_t;

	logic                   valid_s1;
	logic [FINGER_BITS-1:0] finger_s1;
	logic [COORD_BITS-1:0]  x_s1;
	logic [COORD_BITS-1:0]  y_s1;
	logic                   touch_s1;
	logic [TIME_BITS-1:0]   now_s1;
	logic                   accept;
	logic                   oor;
	logic                   y_strip;
	cw_t                    y_ext;
	cw_t                    lim_ext;

	assign in_stall = valid_s1 & full;
	assign accept   = in_valid & ~in_stall;
	assign push     = valid_s1 & ~full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept | (valid_s1 & full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			finger_s1 <= finger;
			x_s1      <= pos_x;
			y_s1      <= pos_y;
			touch_s1  <= touching;
			now_s1    <= now_ms;
		end
	end

	always_comb begin
		y_ext   = cw_t'(y_s1);
		lim_ext = cw_t'(cfg.y_limit);
		oor     = 32'(finger_s1) >= MAX_FINGERS;
		y_strip = cfg.at_high_y ? (y_ext >= lim_ext) : (y_ext <= lim_ext);
	end

	assign push_data = {oor, y_strip, touch_s1, finger_s1, x_s1, y_s1, now_s1};

endmodule
`default_nettype wire

// File: rtl/esgd_queue.sv
// Short first-in first-out queue between the front and back parts.
// Register-based storage; no package dependencies.
`default_nettype none
module esgd_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire [WIDTH-1:0]  push_data,
	output logic             full,
	input  wire              pop,
	output logic             empty,
	output logic [WIDTH-1:0] head
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [AW:0]      cnt_q;

	assign full  = cnt_q == (AW + 1)'(DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW + 1)'(push) - (AW + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue read while empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !empty)
		else $error("queue lost a transaction");

endmodule
`default_nettype wire

// File: rtl/esgd_back.sv
// Back part of the edge swipe gesture detector: per-finger stroke table and output register.
// Pops one classified transaction a cycle unless stalled; updates table, registers result.
// Depends on esgd_pkg.
`default_nettype none
module esgd_back #(
	parameter int MAX_FINGERS = esgd_pkg::MAX_FINGERS_DEF,
	parameter int COORD_BITS  = esgd_pkg::COORD_BITS_DEF,
	parameter int ENTRY_W     = 3 + esgd_pkg::FINGER_BITS + 2 * COORD_BITS
		+ esgd_pkg::TIME_BITS
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire esgd_pkg::cfg_t cfg,
	input  wire                 empty,
	input  wire [ENTRY_W-1:0]   head,
	output logic                pop,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic [1:0]          gesture,
	output logic                status
);
	import esgd_pkg::*;

	localparam int CW    = (COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS;
	localparam int IDX_W = (MAX_FINGERS > 1) ? $clog2(MAX_FINGERS) : 1;
	typedef logic [CW-1:0] cw_t;

	logic                   valid_q [MAX_FINGERS];
	logic                   done_q  [MAX_FINGERS];
	logic [COORD_BITS-1:0]  sx_q    [MAX_FINGERS];
	logic [COORD_BITS-1:0]  sy_q    [MAX_FINGERS];
	logic [TIME_BITS-1:0]   st_q    [MAX_FINGERS];

	logic                   out_valid_q;
	logic [1:0]             gesture_q;
	logic                   status_q;

	logic                   h_oor;
	logic                   h_ystrip;
	logic                   h_touch;
	logic [FINGER_BITS-1:0] h_finger;
	logic [COORD_BITS-1:0]  h_x;
	logic [COORD_BITS-1:0]  h_y;
	logic [TIME_BITS-1:0]   h_now;
	logic [IDX_W-1:0]       idx;

	cw_t                    x;
	cw_t                    y;
	cw_t                    sx;
	cw_t                    sy;
	cw_t                    xs;
	cw_t                    xe;
	cw_t                    off;
	cw_t                    tol;
	cw_t                    lim;
	cw_t                    dy;
	cw_t                    dx;
	logic [TIME_BITS-1:0]   elapsed;
	logic                   cur_valid;
	logic                   cur_done;
	logic                   sy_strip;
	logic                   swipe;
	logic                   drag;

	logic                   clear;
	logic                   start;
	logic                   set_done;
	logic [1:0]             g;

	assign {h_oor, h_ystrip, h_touch, h_finger, h_x, h_y, h_now} = head;
	assign idx = h_finger[IDX_W-1:0];

	assign pop       = ~empty & (~out_valid_q | ~out_stall);
	assign out_valid = out_valid_q;
	assign gesture   = gesture_q;
	assign status    = status_q;

	always_comb begin
		cur_valid = valid_q[idx];
		cur_done  = done_q[idx];
		x   = cw_t'(h_x);
		y   = cw_t'(h_y);
		sx  = cw_t'(sx_q[idx]);
		sy  = cw_t'(sy_q[idx]);
		xs  = cw_t'(cfg.x_start);
		xe  = cw_t'(cfg.x_end);
		off = cw_t'(cfg.min_travel);
		tol = cw_t'(cfg.y_tol);
		lim = cw_t'(cfg.y_limit);
		dy  = (sy > y) ? sy - y : y - sy;
		dx  = (x > sx) ? x - sx : sx - x;
		elapsed  = h_now - st_q[idx];
		sy_strip = cfg.at_high_y ? (sy >= lim) : (sy <= lim);
		swipe = sy_strip && x >= xs && x <= xe &&
			((x > sx && (x - xs) > off) || (x < sx && (xe - x) > off)) && dx > off;
		drag  = sx <= cw_t'(cfg.drag_limit) && sy != '0 && x > sx && dy < tol &&
			(x - sx) > cw_t'(DRAG_MIN_TRAVEL);

		clear    = 1'b0;
		start    = 1'b0;
		set_done = 1'b0;
		g        = GEST_NONE;
		priority if (h_oor) begin
		end else if (!h_touch) begin
			clear = 1'b1;
		end else if (!cur_valid) begin
			start = 1'b1;
		end else if (!h_ystrip && sy_strip) begin
			clear = 1'b1;
		end else if (y != '0 && dy > tol) begin
			clear = 1'b1;
		end else if (swipe) begin
			if (!cur_done && elapsed <= TIME_BITS'(cfg.window_ms)) begin
				g        = (sx < x) ? GEST_SWIPE_UP : GEST_SWIPE_DOWN;
				set_done = 1'b1;
			end
		end else if (drag) begin
			if (!cur_done) begin
				g        = GEST_DRAG;
				set_done = 1'b1;
			end
		end else begin
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_FINGERS; i++) begin
				valid_q[i] <= 1'b0;
				done_q[i]  <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (clear) begin
					valid_q[idx] <= 1'b0;
					done_q[idx]  <= 1'b0;
				end else if (start) begin
					valid_q[idx] <= 1'b1;
					done_q[idx]  <= 1'b0;
				end else if (set_done) begin
					done_q[idx]  <= 1'b1;
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			gesture_q <= g;
			status_q  <= h_oor ? STATUS_BAD : STATUS_OK;
			if (start) begin
				sx_q[idx] <= h_x;
				sy_q[idx] <= h_y;
				st_q[idx] <= h_now;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == STATUS_BAD) |-> gesture_q == GEST_NONE)
		else $error("gesture reported for a bad finger id");
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !h_oor && !h_touch) |=> !valid_q[$past(idx)])
		else $error("lift did not clear the stroke");
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && g != GEST_NONE) |=> done_q[$past(idx)])
		else $error("gesture reported without marking the stroke done");
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !h_oor && h_touch && !cur_valid) |=> valid_q[$past(idx)])
		else $error("first touch did not open a stroke");

endmodule
`default_nettype wire
